// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the complex arithmetic unit.
// Expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CAU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cau_pkg.sv -----
// Shared constants, types and functions of the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PORT_W        = 32;
    localparam int ACT_W         = 3;
    localparam int PROD_W        = 2 * DATA_WIDTH;
    localparam int SUM_W         = PROD_W + 1;
    localparam int MAG_W         = PROD_W;
    localparam int DEN_W         = PROD_W;
    localparam int DIVD_W        = MAG_W + FRACTION_BITS;
    localparam int CMP_W         = DIVD_W + DATA_WIDTH;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACT_W-1:0] ACT_EQ  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NE  = 3'd5;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic                  valid;
        logic                  is_div;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic                  big_re;
        logic                  big_im;
        logic [DEN_W-1:0]      den;
        logic [DEN_W-1:0]      rem_re;
        logic [DEN_W-1:0]      rem_im;
        logic [DATA_WIDTH-1:0] lo_re;
        logic [DATA_WIDTH-1:0] lo_im;
        logic [DATA_WIDTH-1:0] q_re;
        logic [DATA_WIDTH-1:0] q_im;
        word_t                 res_re;
        word_t                 res_im;
        logic                  cmp;
        logic                  ovf;
    } div_t;

    // Split a signed sum into sign and magnitude.
    function automatic logic [MAG_W:0] to_sm(input logic signed [SUM_W-1:0] x);
        logic             neg;
        logic [SUM_W-1:0] m;
        neg = x[SUM_W-1];
        m   = neg ? $unsigned(-x) : $unsigned(x);
        return {neg, m[MAG_W-1:0]};
    endfunction

    // Saturate a sign-magnitude value; returns {overflow, word}.
    function automatic logic [DATA_WIDTH:0] clamp(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0]      lim;
        logic [MAG_W-1:0]      neg_mag;
        logic [DATA_WIDTH-1:0] res;
        logic                  ovf;
        lim     = MAG_W'(1) << (DATA_WIDTH - 1);
        neg_mag = -mag;
        ovf     = 1'b0;
        if (!neg && mag > lim - MAG_W'(1)) begin
            ovf = 1'b1;
            res = DATA_WIDTH'(lim - MAG_W'(1));
        end
        else if (neg && mag > lim) begin
            ovf = 1'b1;
            res = lim[DATA_WIDTH-1:0];
        end
        else if (neg) begin
            res = neg_mag[DATA_WIDTH-1:0];
        end
        else begin
            res = mag[DATA_WIDTH-1:0];
        end
        return {ovf, res};
    endfunction

endpackage

// ----- hw/rtl/cau_div_step.sv -----
// One restoring-division step for both result parts, with its pipeline register.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  cau_pkg::div_t d_in,
    output cau_pkg::div_t d_out
);
    import cau_pkg::*;

    div_t           d_reg;
    div_t           d_next;
    logic [DEN_W:0] r2_re;
    logic [DEN_W:0] r2_im;
    logic [DEN_W:0] den_x;
    logic           ge_re;
    logic           ge_im;

    always_comb
    begin
        d_next = d_in;
        den_x  = {1'b0, d_in.den};
        r2_re  = {d_in.rem_re, d_in.lo_re[DATA_WIDTH-1]};
        r2_im  = {d_in.rem_im, d_in.lo_im[DATA_WIDTH-1]};
        ge_re  = r2_re >= den_x;
        ge_im  = r2_im >= den_x;
        d_next.rem_re = ge_re ? DEN_W'(r2_re - den_x) : DEN_W'(r2_re);
        d_next.rem_im = ge_im ? DEN_W'(r2_im - den_x) : DEN_W'(r2_im);
        d_next.q_re   = {d_in.q_re[DATA_WIDTH-2:0], ge_re};
        d_next.q_im   = {d_in.q_im[DATA_WIDTH-2:0], ge_im};
        d_next.lo_re  = d_in.lo_re << 1;
        d_next.lo_im  = d_in.lo_im << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, subtract, multiply, divide and compare of two
// signed Q16.16 complex operands. Fully pipelined: one item per cycle while the
// output is not stalled, through five operand and product stages, one stage per
// quotient bit of the 32-step divider and one output register. An output stall
// freezes the whole pipeline. Depends on cau_pkg, cau_div_step, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module complex_arithmetic_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cau_pkg::ACT_W-1:0]     action,
    input  logic signed [cau_pkg::PORT_W-1:0] a_re,
    input  logic signed [cau_pkg::PORT_W-1:0] a_im,
    input  logic signed [cau_pkg::PORT_W-1:0] b_re,
    input  logic signed [cau_pkg::PORT_W-1:0] b_im,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [cau_pkg::PORT_W-1:0] res_re,
    output logic signed [cau_pkg::PORT_W-1:0] res_im,
    output logic                          compare_true,
    output logic                          overflow,
    output logic                          div_by_zero
);
    import cau_pkg::*;

    logic en;

    // stage 1: operands
    logic             s1_valid_reg;
    logic [ACT_W-1:0] s1_act_reg;
    word_t            s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // stage 2: products and simple results
    logic                     s2_valid_reg;
    logic [ACT_W-1:0]         s2_act_reg;
    logic signed [PROD_W-1:0] s2_prr_reg, s2_pii_reg, s2_pri_reg, s2_pir_reg;
    logic signed [PROD_W-1:0] s2_sr_reg, s2_si_reg;
    word_t                    s2_res_re_reg, s2_res_im_reg;
    logic                     s2_cmp_reg, s2_ovf_reg;
    word_t                    s2_res_re_next, s2_res_im_next;
    logic                     s2_cmp_next, s2_ovf_next;
    logic signed [SUM_W-1:0]  sum_re, sum_im;
    logic [MAG_W:0]           sm_sum_re, sm_sum_im;
    logic [DATA_WIDTH:0]      cl_re, cl_im;

    // stage 3: sums
    logic                    s3_valid_reg;
    logic [ACT_W-1:0]        s3_act_reg;
    logic signed [SUM_W-1:0] s3_x_re_reg, s3_x_im_reg;
    logic [DEN_W-1:0]        s3_den_reg;
    word_t                   s3_res_re_reg, s3_res_im_reg;
    logic                    s3_cmp_reg, s3_ovf_reg;

    // stage 4: sign and magnitude
    logic             s4_valid_reg;
    logic [ACT_W-1:0] s4_act_reg;
    logic [MAG_W:0]   s4_sm_re_reg, s4_sm_im_reg;
    logic [DEN_W-1:0] s4_den_reg;
    word_t            s4_res_re_reg, s4_res_im_reg;
    logic             s4_cmp_reg, s4_ovf_reg;

    // stage 5: divider entry
    div_t                s5_reg, s5_next;
    logic [DIVD_W-1:0]   d_re, d_im;
    logic [DATA_WIDTH:0] m_re, m_im;

    div_t chain [DATA_WIDTH+1];

    // output
    logic                  out_valid_reg;
    word_t                 out_re_reg, out_im_reg;
    logic                  out_cmp_reg, out_ovf_reg, out_dz_reg;
    div_t                  fin;
    logic [DATA_WIDTH:0]   f_re, f_im;
    word_t                 out_re_next, out_im_next;
    logic                  out_ovf_next, out_dz_next;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // stage 2 simple results
    always_comb
    begin
        s2_res_re_next = '0;
        s2_res_im_next = '0;
        s2_cmp_next    = 1'b0;
        s2_ovf_next    = 1'b0;
        sum_re = (s1_act_reg == ACT_SUB) ? SUM_W'(s1_ar_reg) - SUM_W'(s1_br_reg)
                                         : SUM_W'(s1_ar_reg) + SUM_W'(s1_br_reg);
        sum_im = (s1_act_reg == ACT_SUB) ? SUM_W'(s1_ai_reg) - SUM_W'(s1_bi_reg)
                                         : SUM_W'(s1_ai_reg) + SUM_W'(s1_bi_reg);
        sm_sum_re = to_sm(sum_re);
        sm_sum_im = to_sm(sum_im);
        cl_re  = clamp(sm_sum_re[MAG_W], sm_sum_re[MAG_W-1:0]);
        cl_im  = clamp(sm_sum_im[MAG_W], sm_sum_im[MAG_W-1:0]);
        case (s1_act_reg)
            ACT_ADD, ACT_SUB:
            begin
                s2_res_re_next = cl_re[DATA_WIDTH-1:0];
                s2_res_im_next = cl_im[DATA_WIDTH-1:0];
                s2_ovf_next    = cl_re[DATA_WIDTH] | cl_im[DATA_WIDTH];
            end
            ACT_EQ:
            begin
                s2_cmp_next = (s1_ar_reg == s1_br_reg) && (s1_ai_reg == s1_bi_reg);
            end
            ACT_NE:
            begin
                s2_cmp_next = (s1_ar_reg != s1_br_reg) || (s1_ai_reg != s1_bi_reg);
            end
            default:
            begin
                s2_cmp_next = 1'b0;
            end
        endcase
    end

    // stage 5 entry of the divider, multiply results
    always_comb
    begin
        s5_next        = '0;
        s5_next.valid  = s4_valid_reg;
        s5_next.res_re = s4_res_re_reg;
        s5_next.res_im = s4_res_im_reg;
        s5_next.cmp    = s4_cmp_reg;
        s5_next.ovf    = s4_ovf_reg;
        s5_next.neg_re = s4_sm_re_reg[MAG_W];
        s5_next.neg_im = s4_sm_im_reg[MAG_W];
        s5_next.den    = s4_den_reg;
        d_re = DIVD_W'(s4_sm_re_reg[MAG_W-1:0]) << FRACTION_BITS;
        d_im = DIVD_W'(s4_sm_im_reg[MAG_W-1:0]) << FRACTION_BITS;
        m_re = clamp(s4_sm_re_reg[MAG_W], s4_sm_re_reg[MAG_W-1:0] >> FRACTION_BITS);
        m_im = clamp(s4_sm_im_reg[MAG_W], s4_sm_im_reg[MAG_W-1:0] >> FRACTION_BITS);
        s5_next.big_re = CMP_W'(d_re) >= (CMP_W'(s4_den_reg) << DATA_WIDTH);
        s5_next.big_im = CMP_W'(d_im) >= (CMP_W'(s4_den_reg) << DATA_WIDTH);
        s5_next.rem_re = DEN_W'(d_re >> DATA_WIDTH);
        s5_next.rem_im = DEN_W'(d_im >> DATA_WIDTH);
        s5_next.lo_re  = d_re[DATA_WIDTH-1:0];
        s5_next.lo_im  = d_im[DATA_WIDTH-1:0];
        if (s4_act_reg == ACT_MUL)
        begin
            s5_next.res_re = m_re[DATA_WIDTH-1:0];
            s5_next.res_im = m_im[DATA_WIDTH-1:0];
            s5_next.ovf    = m_re[DATA_WIDTH] | m_im[DATA_WIDTH];
        end
        if (s4_act_reg == ACT_DIV)
        begin
            s5_next.is_div = 1'b1;
            s5_next.dz     = (s4_den_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_reg       <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_reg       <= s5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_act_reg <= action;
            s1_ar_reg  <= a_re[DATA_WIDTH-1:0];
            s1_ai_reg  <= a_im[DATA_WIDTH-1:0];
            s1_br_reg  <= b_re[DATA_WIDTH-1:0];
            s1_bi_reg  <= b_im[DATA_WIDTH-1:0];

            s2_act_reg    <= s1_act_reg;
            s2_prr_reg    <= PROD_W'(s1_ar_reg) * PROD_W'(s1_br_reg);
            s2_pii_reg    <= PROD_W'(s1_ai_reg) * PROD_W'(s1_bi_reg);
            s2_pri_reg    <= PROD_W'(s1_ar_reg) * PROD_W'(s1_bi_reg);
            s2_pir_reg    <= PROD_W'(s1_ai_reg) * PROD_W'(s1_br_reg);
            s2_sr_reg     <= PROD_W'(s1_br_reg) * PROD_W'(s1_br_reg);
            s2_si_reg     <= PROD_W'(s1_bi_reg) * PROD_W'(s1_bi_reg);
            s2_res_re_reg <= s2_res_re_next;
            s2_res_im_reg <= s2_res_im_next;
            s2_cmp_reg    <= s2_cmp_next;
            s2_ovf_reg    <= s2_ovf_next;

            s3_act_reg  <= s2_act_reg;
            s3_x_re_reg <= (s2_act_reg == ACT_MUL)
                ? SUM_W'(s2_prr_reg) - SUM_W'(s2_pii_reg)
                : SUM_W'(s2_prr_reg) + SUM_W'(s2_pii_reg);
            s3_x_im_reg <= (s2_act_reg == ACT_MUL)
                ? SUM_W'(s2_pri_reg) + SUM_W'(s2_pir_reg)
                : SUM_W'(s2_pir_reg) - SUM_W'(s2_pri_reg);
            s3_den_reg    <= $unsigned(s2_sr_reg) + $unsigned(s2_si_reg);
            s3_res_re_reg <= s2_res_re_reg;
            s3_res_im_reg <= s2_res_im_reg;
            s3_cmp_reg    <= s2_cmp_reg;
            s3_ovf_reg    <= s2_ovf_reg;

            s4_act_reg    <= s3_act_reg;
            s4_sm_re_reg  <= to_sm(s3_x_re_reg);
            s4_sm_im_reg  <= to_sm(s3_x_im_reg);
            s4_den_reg    <= s3_den_reg;
            s4_res_re_reg <= s3_res_re_reg;
            s4_res_im_reg <= s3_res_im_reg;
            s4_cmp_reg    <= s3_cmp_reg;
            s4_ovf_reg    <= s3_ovf_reg;
        end
    end

    assign chain[0] = s5_reg;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_div
        cau_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    // final saturation of the quotients, division-by-zero result and output selection
    always_comb
    begin
        fin  = chain[DATA_WIDTH];
        f_re = clamp(fin.neg_re, fin.big_re ? '1 : MAG_W'(fin.q_re));
        f_im = clamp(fin.neg_im, fin.big_im ? '1 : MAG_W'(fin.q_im));
        out_re_next  = fin.res_re;
        out_im_next  = fin.res_im;
        out_ovf_next = fin.ovf;
        out_dz_next  = 1'b0;
        if (fin.is_div && fin.dz)
        begin
            out_re_next  = '0;
            out_im_next  = '0;
            out_ovf_next = 1'b0;
            out_dz_next  = 1'b1;
        end
        else if (fin.is_div)
        begin
            out_re_next  = f_re[DATA_WIDTH-1:0];
            out_im_next  = f_im[DATA_WIDTH-1:0];
            out_ovf_next = f_re[DATA_WIDTH] | f_im[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg  <= out_re_next;
            out_im_reg  <= out_im_next;
            out_cmp_reg <= fin.cmp;
            out_ovf_reg <= out_ovf_next;
            out_dz_reg  <= out_dz_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign res_re       = PORT_W'(out_re_reg);
    assign res_im       = PORT_W'(out_im_reg);
    assign compare_true = out_cmp_reg;
    assign overflow     = out_ovf_reg;
    assign div_by_zero  = out_dz_reg;

    `CAU_ASSERT(a_stall_follows_output, in_stall == (out_valid && out_stall), "stall mismatch")
    `CAU_ASSERT_IMPL(a_dz_zero, out_valid && div_by_zero, res_re == '0 && res_im == '0 && !overflow, "div by zero result not clean")
    `CAU_ASSERT_IMPL(a_cmp_clean, out_valid && compare_true, !overflow && !div_by_zero && res_re == '0 && res_im == '0, "compare result not clean")

endmodule
